// ===== design/alu6502_pkg.sv =====
// Types and operation codes shared by the 6502-style ALU pipeline.
package alu6502_pkg;

  typedef enum logic [4:0] {
    OP_ADC     = 5'd0,
    OP_SBC     = 5'd1,
    OP_ASL_A   = 5'd2,
    OP_ASL_M   = 5'd3,
    OP_LSR_A   = 5'd4,
    OP_LSR_M   = 5'd5,
    OP_ROL_A   = 5'd6,
    OP_ROL_M   = 5'd7,
    OP_ROR_A   = 5'd8,
    OP_ROR_M   = 5'd9,
    OP_AND     = 5'd10,
    OP_ORA     = 5'd11,
    OP_EOR     = 5'd12,
    OP_CMP     = 5'd13,
    OP_CPX     = 5'd14,
    OP_CPY     = 5'd15,
    OP_BIT     = 5'd16,
    OP_BRANCH  = 5'd17,
    OP_LAX     = 5'd18,
    OP_SAX     = 5'd19,
    OP_DCP     = 5'd20,
    OP_ISC     = 5'd21,
    OP_SLO     = 5'd22,
    OP_RLA     = 5'd23,
    OP_SRE     = 5'd24,
    OP_RRA     = 5'd25,
    OP_ANC     = 5'd26,
    OP_ALR     = 5'd27,
    OP_ARR     = 5'd28,
    OP_SBX     = 5'd29
  } op_t;

  // flag bit positions
  localparam int FLAG_N = 3;
  localparam int FLAG_V = 2;
  localparam int FLAG_Z = 1;
  localparam int FLAG_C = 0;

  typedef struct packed {
    logic [4:0]  opcode;
    logic [7:0]  acc_in;
    logic [7:0]  x_in;
    logic [7:0]  y_in;
    logic [3:0]  flags_in;
    logic [7:0]  operand;
    logic [15:0] pc_in;
  } alu_req_t;

  typedef struct packed {
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [3:0]  flags_out;
    logic [7:0]  mem_out;
    logic        mem_write;
    logic [15:0] pc_out;
    logic        page_crossed;
  } alu_rsp_t;

endpackage

// ===== design/alu_6502_with_flags.sv =====
// Four-stage pipelined 6502-style ALU with flag generation.
//
// Channels: the request channel (op_valid, op_stall, op_data) carries one
// operation with A, X, Y, flags, operand byte and PC; the result channel
// (res_valid, res_stall, res_data) carries new A, X, flags, the memory
// write-back byte with its enable, and the branch PC with its page mark.
// A transfer happens at a clock edge with valid high and stall low.
//
// Stages: input register; operand modify (shift, rotate, inc/dec, AND
// combos) and branch target add; 8-bit adder, logic ops and result
// select; flag assembly into the output register.
// Throughput: one operation per cycle unless the receiver stalls;
// every stage holds one item and advances whenever the stage after
// it is empty or moving.
//
// Reset clears all stage valid bits; the pipeline comes up empty.
// When the receiver stalls, items pile up behind the output register,
// filling bubbles first; op_stall rises only when all four stages hold
// an item and the output is stalled. Nothing is dropped or repeated.
module alu_6502_with_flags
  import alu6502_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     op_valid,
  output logic     op_stall,
  input  alu_req_t op_data,
  output logic     res_valid,
  input  logic     res_stall,
  output alu_rsp_t res_data
);

  typedef struct packed {
    op_t         op;
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [3:0]  f;
    logic [7:0]  m;
    logic [7:0]  t;      // modified operand
    logic        t_c;    // carry out of the shift/rotate
    logic [15:0] pc;
    logic        pg;
  } s2_t;

  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  x;
    logic [3:0]  f;
    logic [7:0]  r;      // byte that sets Z
    logic        n_src;
    logic        upd_nz;
    logic        c;
    logic        upd_c;
    logic        v;
    logic        upd_v;
    logic [7:0]  mo;
    logic        mw;
    logic [15:0] pc;
    logic        pg;
  } s3_t;

  logic     v1, v2, v3, v4;
  logic     rdy1, rdy2, rdy3, rdy4;
  alu_req_t s1;
  s2_t      s2, s2_next;
  s3_t      s3, s3_next;
  alu_rsp_t s4, s4_next;

  assign rdy4 = !v4 || !res_stall;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign op_stall  = !rdy1;
  assign res_valid = v4;
  assign res_data  = s4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= op_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1 <= op_data;
    if (rdy2) s2 <= s2_next;
    if (rdy3) s3 <= s3_next;
    if (rdy4) s4 <= s4_next;
  end

  // stage 1 -> 2: operand modify and branch target
  always_comb begin
    logic [7:0]  a, m, am;
    logic        cin;
    logic [15:0] tgt;
    a   = s1.acc_in;
    m   = s1.operand;
    am  = a & m;
    cin = s1.flags_in[FLAG_C];
    tgt = s1.pc_in + {{8{m[7]}}, m};

    s2_next.op  = op_t'(s1.opcode);
    s2_next.a   = a;
    s2_next.x   = s1.x_in;
    s2_next.y   = s1.y_in;
    s2_next.f   = s1.flags_in;
    s2_next.m   = m;
    s2_next.t   = m;
    s2_next.t_c = 1'b0;
    s2_next.pc  = s1.pc_in;
    s2_next.pg  = 1'b0;

    unique case (op_t'(s1.opcode)) inside
      OP_ASL_A: begin
        s2_next.t = {a[6:0], 1'b0}; s2_next.t_c = a[7];
      end
      OP_ASL_M, OP_SLO: begin
        s2_next.t = {m[6:0], 1'b0}; s2_next.t_c = m[7];
      end
      OP_LSR_A: begin
        s2_next.t = {1'b0, a[7:1]}; s2_next.t_c = a[0];
      end
      OP_LSR_M, OP_SRE: begin
        s2_next.t = {1'b0, m[7:1]}; s2_next.t_c = m[0];
      end
      OP_ROL_A: begin
        s2_next.t = {a[6:0], cin}; s2_next.t_c = a[7];
      end
      OP_ROL_M, OP_RLA: begin
        s2_next.t = {m[6:0], cin}; s2_next.t_c = m[7];
      end
      OP_ROR_A: begin
        s2_next.t = {cin, a[7:1]}; s2_next.t_c = a[0];
      end
      OP_ROR_M, OP_RRA: begin
        s2_next.t = {cin, m[7:1]}; s2_next.t_c = m[0];
      end
      OP_AND, OP_ANC, OP_BIT: s2_next.t = am;
      OP_ORA:  s2_next.t = a | m;
      OP_EOR:  s2_next.t = a ^ m;
      OP_DCP:  s2_next.t = m - 8'd1;
      OP_ISC:  s2_next.t = m + 8'd1;
      OP_SAX, OP_SBX: s2_next.t = a & s1.x_in;
      OP_ALR: begin
        s2_next.t = {1'b0, am[7:1]}; s2_next.t_c = am[0];
      end
      OP_ARR:  s2_next.t = {cin, am[7:1]};
      OP_BRANCH: begin
        s2_next.pc = tgt;
        s2_next.pg = tgt[15:8] != s1.pc_in[15:8];
      end
      default: ;
    endcase
  end

  // stage 2 -> 3: shared adder/subtractor and result select
  always_comb begin
    logic [7:0] add_a, add_b, sum;
    logic       add_ci, co, ov;
    logic [8:0] wide;

    add_a  = s2.a;
    add_b  = s2.m;
    add_ci = s2.f[FLAG_C];
    unique case (s2.op)
      OP_SBC: add_b = ~s2.m;
      OP_ISC: add_b = ~s2.t;
      OP_RRA: begin
        add_b = s2.t; add_ci = s2.t_c;
      end
      OP_CMP: begin
        add_b = ~s2.m; add_ci = 1'b1;
      end
      OP_CPX: begin
        add_a = s2.x; add_b = ~s2.m; add_ci = 1'b1;
      end
      OP_CPY: begin
        add_a = s2.y; add_b = ~s2.m; add_ci = 1'b1;
      end
      OP_DCP: begin
        add_b = ~s2.t; add_ci = 1'b1;
      end
      OP_SBX: begin
        add_a = s2.t; add_b = ~s2.m; add_ci = 1'b1;
      end
      default: ;
    endcase
    wide = {1'b0, add_a} + {1'b0, add_b} + {8'd0, add_ci};
    sum  = wide[7:0];
    co   = wide[8];
    ov   = ~(add_a[7] ^ add_b[7]) & (add_a[7] ^ sum[7]);

    s3_next.a      = s2.a;
    s3_next.x      = s2.x;
    s3_next.f      = s2.f;
    s3_next.r      = s2.t;
    s3_next.n_src  = s2.t[7];
    s3_next.upd_nz = 1'b0;
    s3_next.c      = s2.t_c;
    s3_next.upd_c  = 1'b0;
    s3_next.v      = ov;
    s3_next.upd_v  = 1'b0;
    s3_next.mo     = 8'd0;
    s3_next.mw     = 1'b0;
    s3_next.pc     = s2.pc;
    s3_next.pg     = s2.pg;

    unique case (s2.op) inside
      OP_ADC, OP_SBC, OP_ISC, OP_RRA: begin
        s3_next.a      = sum;
        s3_next.r      = sum;
        s3_next.n_src  = sum[7];
        s3_next.c      = co;
        s3_next.upd_nz = 1'b1;
        s3_next.upd_c  = 1'b1;
        s3_next.upd_v  = 1'b1;
        if (s2.op == OP_ISC || s2.op == OP_RRA) begin
          s3_next.mo = s2.t;
          s3_next.mw = 1'b1;
        end
      end
      OP_ASL_A, OP_LSR_A, OP_ROL_A, OP_ROR_A, OP_ALR: begin
        s3_next.a      = s2.t;
        s3_next.upd_nz = 1'b1;
        s3_next.upd_c  = 1'b1;
      end
      OP_ASL_M, OP_LSR_M, OP_ROL_M, OP_ROR_M: begin
        s3_next.mo     = s2.t;
        s3_next.mw     = 1'b1;
        s3_next.upd_nz = 1'b1;
        s3_next.upd_c  = 1'b1;
      end
      OP_AND, OP_ORA, OP_EOR: begin
        s3_next.a      = s2.t;
        s3_next.upd_nz = 1'b1;
      end
      OP_CMP, OP_CPX, OP_CPY, OP_DCP, OP_SBX: begin
        s3_next.r      = sum;
        s3_next.n_src  = sum[7];
        s3_next.c      = co;
        s3_next.upd_nz = 1'b1;
        s3_next.upd_c  = 1'b1;
        if (s2.op == OP_DCP) begin
          s3_next.mo = s2.t;
          s3_next.mw = 1'b1;
        end
        if (s2.op == OP_SBX) s3_next.x = sum;
      end
      OP_BIT: begin
        // Z from A & M, N and V straight from the operand
        s3_next.n_src  = s2.m[7];
        s3_next.v      = s2.m[6];
        s3_next.upd_nz = 1'b1;
        s3_next.upd_v  = 1'b1;
      end
      OP_LAX: begin
        s3_next.a      = s2.m;
        s3_next.x      = s2.m;
        s3_next.r      = s2.m;
        s3_next.n_src  = s2.m[7];
        s3_next.upd_nz = 1'b1;
      end
      OP_SAX: begin
        s3_next.mo = s2.t;
        s3_next.mw = 1'b1;
      end
      OP_SLO, OP_RLA, OP_SRE: begin
        s3_next.mo = s2.t;
        s3_next.mw = 1'b1;
        if (s2.op == OP_SLO)      s3_next.r = s2.a | s2.t;
        else if (s2.op == OP_RLA) s3_next.r = s2.a & s2.t;
        else                      s3_next.r = s2.a ^ s2.t;
        s3_next.a      = s3_next.r;
        s3_next.n_src  = s3_next.r[7];
        s3_next.upd_nz = 1'b1;
        s3_next.upd_c  = 1'b1;
      end
      OP_ANC: begin
        s3_next.a      = s2.t;
        s3_next.c      = s2.t[7];
        s3_next.upd_nz = 1'b1;
        s3_next.upd_c  = 1'b1;
      end
      OP_ARR: begin
        s3_next.a      = s2.t;
        s3_next.c      = s2.t[6];
        s3_next.v      = s2.t[6] ^ s2.t[5];
        s3_next.upd_nz = 1'b1;
        s3_next.upd_c  = 1'b1;
        s3_next.upd_v  = 1'b1;
      end
      default: ;
    endcase
  end

  // stage 3 -> 4: flag assembly
  always_comb begin
    s4_next.acc_out      = s3.a;
    s4_next.x_out        = s3.x;
    s4_next.mem_out      = s3.mo;
    s4_next.mem_write    = s3.mw;
    s4_next.pc_out       = s3.pc;
    s4_next.page_crossed = s3.pg;
    s4_next.flags_out[FLAG_N] = s3.upd_nz ? s3.n_src      : s3.f[FLAG_N];
    s4_next.flags_out[FLAG_V] = s3.upd_v  ? s3.v          : s3.f[FLAG_V];
    s4_next.flags_out[FLAG_Z] = s3.upd_nz ? (s3.r == 8'd0) : s3.f[FLAG_Z];
    s4_next.flags_out[FLAG_C] = s3.upd_c  ? s3.c          : s3.f[FLAG_C];
  end

  a_mem_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.mem_write |-> res_data.mem_out == 8'd0)
    else $error("mem_out nonzero without mem_write");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    op_stall |-> v1 && v2 && v3 && v4 && res_stall)
    else $error("request stalled with room in the pipeline");

  a_s3_hold: assert property (@(posedge clk) disable iff (rst)
    v3 && !rdy4 |=> v3 && $stable(s3))
    else $error("stage 3 item changed while blocked");

  a_s1_advance: assert property (@(posedge clk) disable iff (rst)
    v1 && rdy2 |=> v2)
    else $error("stage 1 item lost on advance");

endmodule
